// File: rtl/urrft_pkg.sv
package urrft_pkg;

    localparam int MAX_SLOTS_DEF   = 16;
    localparam int ADDR_W          = 4;
    localparam int IN_DATA_W       = 32;
    localparam int IN_USER_W       = 4;
    localparam int OUT_DATA_W      = 200;

    localparam logic [15:0] RING_LEN_RESET = 16'd256;
    localparam logic [4:0]  SLOTS_RESET    = 5'd8;
    localparam logic        FRAMING_RESET  = 1'b0;
    localparam logic        DMA_MODE_RESET = 1'b1;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_RING_LENGTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_SLOTS  = 2'd1;
    localparam logic [1:0] REG_IDLE_FRAMING = 2'd2;
    localparam logic [1:0] REG_DMA_MODE     = 2'd3;

    localparam logic [2:0] KIND_DMA_EVENT  = 3'd0;
    localparam logic [2:0] KIND_SEG_END    = 3'd1;
    localparam logic [2:0] KIND_STREAM_RD  = 3'd2;
    localparam logic [2:0] KIND_FRAME_RD   = 3'd3;
    localparam logic [2:0] KIND_REARM      = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_POS,
        ST_M_OLD,
        ST_DMA_UPD,
        ST_DMA_CHK,
        ST_M_FB,
        ST_M_WIDX,
        ST_QUEUE,
        ST_M_BASE,
        ST_SEG_UPD,
        ST_SEG_CHK,
        ST_M_ARM,
        ST_M_CONS,
        ST_RD_GRANT,
        ST_RD_ADD,
        ST_M_RIDX,
        ST_FR_POP,
        ST_DONE
    } state_t;

endpackage

// File: rtl/uart_rx_ring_frame_tracker.sv
// Receive-side accounting for a circular UART receive ring.
// Input channel (s_*): one beat per event. kind in s_tuser selects a DMA position
// report, a segment end, a stream read, a frame read or a rearm.
// Output channel (m_*): exactly one result beat per input beat, in order.
// Configuration: APB-style port, ring_length at 0x0, frame_slots at 0x4,
// idle_framing at 0x8, dma_mode at 0xC; pready is tied high.
// All ring offsets and descriptor ring indices come from one shared remainder
// unit, driven by a small sequencer. Rearm, ignored kinds and frame reads on an
// empty ring take no remainder; a stream read takes that of the consumed total;
// a frame read, the next read index; a segment end, the old and new write totals,
// plus the next write index when a frame is queued; a DMA report, the position
// and write total, plus frame begin and write index when queued (four remainders).
// One item is in work at a time; s_tready is high only in idle.
// A finished result sits in the output register; the next input beat is taken
// while it waits. If the receiver stalls, the following result holds in the
// sequencer until the output register frees, and input stays blocked.
// Reset clears all totals, indices, counters and the output valid flag, and
// loads the configuration defaults. Descriptor slots are not cleared.
module uart_rx_ring_frame_tracker
    import urrft_pkg::*;
#(
    parameter int MAX_FRAME_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // position[15:0], request[31:16]
    input  logic [IN_USER_W-1:0]  s_tuser,   // kind[2:0], idle_event[3]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // available[15:0], read_offset[31:16], read_length[47:32], frame_valid[48],
    // frame_full_length[64:49], ring_overrun[65], frame_dropped[66],
    // arm_offset[82:67], arm_length[98:83], overrun_total[130:99],
    // received_total[162:131], frames_total[194:163], zero fill[199:195]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;

    // configuration
    logic [15:0] ring_length_reg;
    logic [4:0]  frame_slots_reg;
    logic        idle_framing_reg;
    logic        dma_mode_reg;
    logic        cfg_write;

    // accounting state
    state_t      state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [31:0] written_reg, written_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] fbegin_reg, fbegin_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [31:0] ovr_cnt_reg, ovr_cnt_next;
    logic [31:0] rx_cnt_reg, rx_cnt_next;
    logic [31:0] fr_cnt_reg, fr_cnt_next;

    // latched item and scratch
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] pos_reg, pos_next;
    logic        idle_reg, idle_next;
    logic [15:0] req_reg, req_next;
    logic [15:0] opa_reg, opa_next;
    logic [15:0] opb_reg, opb_next;

    // result fields
    logic [15:0] rd_off_reg, rd_off_next;
    logic [15:0] rd_len_reg, rd_len_next;
    logic        fvalid_reg, fvalid_next;
    logic [15:0] ffull_reg, ffull_next;
    logic        ovr_reg, ovr_next;
    logic        drop_reg, drop_next;
    logic [15:0] arm_off_reg, arm_off_next;
    logic [15:0] arm_len_reg, arm_len_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // descriptor ring
    logic [15:0] desc_off_reg [MAX_FRAME_SLOTS];
    logic [15:0] desc_len_reg [MAX_FRAME_SLOTS];
    logic        desc_we;
    logic [15:0] desc_off_wr, desc_len_wr;

    // shared remainder unit
    logic        mod_start, mod_done;
    logic [31:0] mod_dividend;
    logic [15:0] mod_divisor, mod_rem;

    logic [15:0] len_eff;
    logic [4:0]  slots_eff;
    logic [31:0] unread;
    logic [16:0] fresh;
    logic [31:0] qlen;
    logic [15:0] avail;
    logic [15:0] pop_len;
    logic        is_mod_state;

    assign len_eff   = (ring_length_reg == 16'd0) ? 16'd1 : ring_length_reg;
    assign slots_eff = (frame_slots_reg == 5'd0) ? 5'd1 :
                       (frame_slots_reg > 5'(MAX_FRAME_SLOTS)) ? 5'(MAX_FRAME_SLOTS) :
                       frame_slots_reg;
    assign unread    = written_reg - consumed_reg;
    assign avail     = unread[15:0];
    assign pop_len   = desc_len_reg[ridx_reg];
    assign fresh     = (opa_reg >= opb_reg) ? {1'b0, opa_reg} - {1'b0, opb_reg}
                     : {1'b0, opa_reg} + {1'b0, len_eff} - {1'b0, opb_reg};
    assign qlen      = (kind_reg == KIND_DMA_EVENT) ? written_reg - fbegin_reg
                     : {16'd0, pos_reg};

    urrft_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // operand select for the remainder unit
    always_comb
    begin
        mod_dividend = written_reg;
        mod_divisor  = len_eff;
        is_mod_state = 1'b1;
        case (state_reg)
            ST_M_POS:  mod_dividend = {16'd0, pos_reg};
            ST_M_OLD:  mod_dividend = written_reg;
            ST_M_FB:   mod_dividend = fbegin_reg;
            ST_M_BASE: mod_dividend = written_reg;
            ST_M_ARM:  mod_dividend = written_reg;
            ST_M_CONS: mod_dividend = consumed_reg;
            ST_M_WIDX:
            begin
                mod_dividend = 32'(widx_reg) + 32'd1;
                mod_divisor  = {11'd0, slots_eff};
            end
            ST_M_RIDX:
            begin
                mod_dividend = 32'(ridx_reg) + 32'd1;
                mod_divisor  = {11'd0, slots_eff};
            end
            default:   is_mod_state = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        issued_next   = issued_reg;
        written_next  = written_reg;
        consumed_next = consumed_reg;
        fbegin_next   = fbegin_reg;
        widx_next     = widx_reg;
        ridx_next     = ridx_reg;
        ovr_cnt_next  = ovr_cnt_reg;
        rx_cnt_next   = rx_cnt_reg;
        fr_cnt_next   = fr_cnt_reg;
        kind_next     = kind_reg;
        pos_next      = pos_reg;
        idle_next     = idle_reg;
        req_next      = req_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        rd_off_next   = rd_off_reg;
        rd_len_next   = rd_len_reg;
        fvalid_next   = fvalid_reg;
        ffull_next    = ffull_reg;
        ovr_next      = ovr_reg;
        drop_next     = drop_reg;
        arm_off_next  = arm_off_reg;
        arm_len_next  = arm_len_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        mod_start     = 1'b0;
        desc_we       = 1'b0;
        desc_off_wr   = opa_reg;
        desc_len_wr   = (qlen > {16'd0, len_eff}) ? len_eff : qlen[15:0];

        // launch the remainder once, wait for it
        if (is_mod_state && !issued_reg)
        begin
            mod_start   = 1'b1;
            issued_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next    = s_tuser[2:0];
                    idle_next    = s_tuser[3];
                    pos_next     = s_tdata[15:0];
                    req_next     = s_tdata[31:16];
                    rd_off_next  = '0;
                    rd_len_next  = '0;
                    fvalid_next  = 1'b0;
                    ffull_next   = '0;
                    ovr_next     = 1'b0;
                    drop_next    = 1'b0;
                    arm_off_next = '0;
                    arm_len_next = '0;
                    state_next   = ST_DONE;
                    case (s_tuser[2:0])
                        KIND_DMA_EVENT: if (dma_mode_reg) state_next = ST_M_POS;
                        KIND_SEG_END:   if (!dma_mode_reg) state_next = ST_M_BASE;
                        KIND_STREAM_RD: state_next = ST_M_CONS;
                        KIND_FRAME_RD:  if (ridx_reg != widx_reg) state_next = ST_M_RIDX;
                        KIND_REARM:
                        begin
                            written_next  = '0;
                            consumed_next = '0;
                            fbegin_next   = '0;
                            widx_next     = '0;
                            ridx_next     = '0;
                            if (!dma_mode_reg) arm_len_next = len_eff;
                        end
                        default: ;
                    endcase
                end
            end
            ST_M_POS:
            begin
                if (issued_reg && mod_done)
                begin
                    opa_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_M_OLD;
                end
            end
            ST_M_OLD:
            begin
                if (issued_reg && mod_done)
                begin
                    opb_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_DMA_UPD;
                end
            end
            ST_DMA_UPD:
            begin
                written_next = written_reg + 32'(fresh);
                rx_cnt_next  = rx_cnt_reg + 32'(fresh);
                state_next   = ST_DMA_CHK;
            end
            ST_DMA_CHK, ST_SEG_CHK:
            begin
                state_next = (state_reg == ST_SEG_CHK) ? ST_M_ARM : ST_DONE;
                if (unread > {16'd0, len_eff})
                begin
                    // overrun: restart read and frame accounting at the write total
                    ovr_cnt_next  = ovr_cnt_reg + 32'd1;
                    consumed_next = written_reg;
                    fbegin_next   = written_reg;
                    widx_next     = '0;
                    ridx_next     = '0;
                    ovr_next      = 1'b1;
                end
                else if (state_reg == ST_DMA_CHK)
                begin
                    if (idle_framing_reg && idle_reg && written_reg != fbegin_reg)
                        state_next = ST_M_FB;
                end
                else if (idle_framing_reg && pos_reg != 16'd0)
                begin
                    state_next = ST_M_WIDX;
                end
            end
            ST_M_FB:
            begin
                if (issued_reg && mod_done)
                begin
                    opa_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_M_WIDX;
                end
            end
            ST_M_WIDX:
            begin
                if (issued_reg && mod_done)
                begin
                    opb_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_QUEUE;
                end
            end
            ST_QUEUE:
            begin
                if (opb_reg[IDX_W-1:0] != ridx_reg)
                begin
                    desc_we   = 1'b1;
                    widx_next = opb_reg[IDX_W-1:0];
                end
                else
                begin
                    // descriptor ring full: drop the frame
                    ovr_cnt_next = ovr_cnt_reg + 32'd1;
                    drop_next    = 1'b1;
                end
                fbegin_next = written_reg;
                state_next  = (kind_reg == KIND_SEG_END) ? ST_M_ARM : ST_DONE;
            end
            ST_M_BASE:
            begin
                if (issued_reg && mod_done)
                begin
                    opa_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_SEG_UPD;
                end
            end
            ST_SEG_UPD:
            begin
                written_next = written_reg + {16'd0, pos_reg};
                rx_cnt_next  = rx_cnt_reg + {16'd0, pos_reg};
                state_next   = ST_SEG_CHK;
            end
            ST_M_ARM:
            begin
                if (issued_reg && mod_done)
                begin
                    arm_off_next = mod_rem;
                    arm_len_next = len_eff - mod_rem;
                    issued_next  = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_M_CONS:
            begin
                if (issued_reg && mod_done)
                begin
                    rd_off_next = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_RD_GRANT;
                end
            end
            ST_RD_GRANT:
            begin
                rd_len_next = (req_reg > avail) ? avail : req_reg;
                state_next  = ST_RD_ADD;
            end
            ST_RD_ADD:
            begin
                consumed_next = consumed_reg + {16'd0, rd_len_reg};
                state_next    = ST_DONE;
            end
            ST_M_RIDX:
            begin
                if (issued_reg && mod_done)
                begin
                    opb_next    = mod_rem;
                    issued_next = 1'b0;
                    state_next  = ST_FR_POP;
                end
            end
            ST_FR_POP:
            begin
                // pop one descriptor, consume the whole frame
                ridx_next     = opb_reg[IDX_W-1:0];
                rd_off_next   = desc_off_reg[ridx_reg];
                rd_len_next   = (pop_len > req_reg) ? req_reg : pop_len;
                consumed_next = consumed_reg + {16'd0, pop_len};
                fr_cnt_next   = fr_cnt_reg + 32'd1;
                fvalid_next   = 1'b1;
                ffull_next    = pop_len;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, fr_cnt_reg, rx_cnt_reg, ovr_cnt_reg,
                                     arm_len_reg, arm_off_reg, drop_reg, ovr_reg,
                                     ffull_reg, fvalid_reg, rd_len_reg, rd_off_reg,
                                     avail};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            written_reg  <= '0;
            consumed_reg <= '0;
            fbegin_reg   <= '0;
            widx_reg     <= '0;
            ridx_reg     <= '0;
            ovr_cnt_reg  <= '0;
            rx_cnt_reg   <= '0;
            fr_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            written_reg  <= written_next;
            consumed_reg <= consumed_next;
            fbegin_reg   <= fbegin_next;
            widx_reg     <= widx_next;
            ridx_reg     <= ridx_next;
            ovr_cnt_reg  <= ovr_cnt_next;
            rx_cnt_reg   <= rx_cnt_next;
            fr_cnt_reg   <= fr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        pos_reg     <= pos_next;
        idle_reg    <= idle_next;
        req_reg     <= req_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        rd_off_reg  <= rd_off_next;
        rd_len_reg  <= rd_len_next;
        fvalid_reg  <= fvalid_next;
        ffull_reg   <= ffull_next;
        ovr_reg     <= ovr_next;
        drop_reg    <= drop_next;
        arm_off_reg <= arm_off_next;
        arm_len_reg <= arm_len_next;
        m_tdata_reg <= m_tdata_next;
        if (desc_we)
        begin
            desc_off_reg[widx_reg] <= desc_off_wr;
            desc_len_reg[widx_reg] <= desc_len_wr;
        end
    end

    // configuration registers
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg  <= RING_LEN_RESET;
            frame_slots_reg  <= SLOTS_RESET;
            idle_framing_reg <= FRAMING_RESET;
            dma_mode_reg     <= DMA_MODE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_RING_LENGTH:  ring_length_reg  <= pwdata[15:0];
                REG_FRAME_SLOTS:  frame_slots_reg  <= pwdata[4:0];
                REG_IDLE_FRAMING: idle_framing_reg <= pwdata[0];
                REG_DMA_MODE:     dma_mode_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RING_LENGTH:  prdata = {16'd0, ring_length_reg};
            REG_FRAME_SLOTS:  prdata = {27'd0, frame_slots_reg};
            REG_IDLE_FRAMING: prdata = {31'd0, idle_framing_reg};
            REG_DMA_MODE:     prdata = {31'd0, dma_mode_reg};
            default:          prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/urrft_mod.sv
// Restoring remainder unit: one quotient bit per cycle, one for each dividend bit.
module urrft_mod
    import urrft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);

    logic [31:0] dq_reg, dq_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], dq_reg[31]};
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
            dq_next  = {dq_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[15:0];

endmodule

// File: rtl/urrft_checker.sv
module urrft_checker
    import urrft_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  pready
);

    // one item at a time: input closes right after a beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:195] == '0)
        else $error("result padding not zero");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind uart_rx_ring_frame_tracker urrft_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// File: tb/sv/ring_tracker_checker.sv
module ring_tracker_checker
    import urrft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [4:0]  fill;
        logic [31:0] frames_total;
        logic [31:0] received_total;
        logic [31:0] overrun_total;
        logic [15:0] arm_length;
        logic [15:0] arm_offset;
        logic        frame_dropped;
        logic        ring_overrun;
        logic [15:0] frame_full_length;
        logic        frame_valid;
        logic [15:0] read_length;
        logic [15:0] read_offset;
        logic [15:0] available;
    } ring_result_t;

    ring_result_t expected_beats[$];

    // configuration copy
    logic [15:0] ring_len_cfg;
    logic [4:0]  slots_cfg;
    logic        framing_cfg;
    logic        dma_cfg;

    // accounting copy
    logic [31:0] written, consumed, frame_mark;
    logic [3:0]  wr_idx, rd_idx;
    logic [15:0] slot_offset [16];
    logic [15:0] slot_length [16];
    logic [31:0] overruns, received, frames;

    function automatic logic [31:0] ring_len_eff();
        return (ring_len_cfg == 16'd0) ? 32'd1 : {16'd0, ring_len_cfg};
    endfunction

    function automatic logic [31:0] slots_eff();
        if (slots_cfg == 5'd0)
            return 32'd1;
        if (slots_cfg > 5'd16)
            return 32'd16;
        return {27'd0, slots_cfg};
    endfunction

    task automatic restart_on_overrun(input logic [31:0] len, output logic hit);
        hit = 1'b0;
        if ((written - consumed) > len)
        begin
            hit = 1'b1;
            overruns++;
            consumed = written;
            frame_mark = written;
            wr_idx = 4'd0;
            rd_idx = 4'd0;
        end
    endtask

    task automatic push_frame(input logic [31:0] off, input logic [31:0] flen,
                              input logic [31:0] len, output logic dropped);
        logic [31:0] nxt;
        nxt = ({28'd0, wr_idx} + 32'd1) % slots_eff();
        dropped = 1'b0;
        if (nxt[3:0] != rd_idx)
        begin
            slot_offset[wr_idx] = off[15:0];
            slot_length[wr_idx] = (flen > len) ? len[15:0] : flen[15:0];
            wr_idx = nxt[3:0];
        end
        else
        begin
            overruns++;
            dropped = 1'b1;
        end
    endtask

    task automatic advance_ring_accounting(input logic [2:0] kind, input logic [15:0] pos,
                                           input logic idle, input logic [15:0] req,
                                           output ring_result_t r);
        logic [31:0] len, p, o, fresh, flen, base, av, nxt;
        logic        hit, dropped;
        len = ring_len_eff();
        r = '0;
        if (kind == KIND_DMA_EVENT && dma_cfg)
        begin
            p = {16'd0, pos} % len;
            o = written % len;
            fresh = (p >= o) ? p - o : p + len - o;
            written += fresh;
            received += fresh;
            restart_on_overrun(len, hit);
            r.ring_overrun = hit;
            if (!hit && framing_cfg && idle)
            begin
                flen = written - frame_mark;
                if (flen > 0)
                begin
                    push_frame(frame_mark % len, flen, len, dropped);
                    r.frame_dropped = dropped;
                    frame_mark = written;
                end
            end
        end
        else if (kind == KIND_SEG_END && !dma_cfg)
        begin
            base = written;
            written += pos;
            received += pos;
            restart_on_overrun(len, hit);
            r.ring_overrun = hit;
            if (!hit && framing_cfg && pos != 16'd0)
            begin
                push_frame(base % len, {16'd0, pos}, len, dropped);
                r.frame_dropped = dropped;
                frame_mark = written;
            end
            o = written % len;
            r.arm_offset = o[15:0];
            p = len - o;
            r.arm_length = p[15:0];
        end
        else if (kind == KIND_STREAM_RD)
        begin
            av = (written - consumed) & 32'hFFFF;
            p = ({16'd0, req} > av) ? av : {16'd0, req};
            o = consumed % len;
            r.read_length = p[15:0];
            r.read_offset = o[15:0];
            consumed += p;
        end
        else if (kind == KIND_FRAME_RD)
        begin
            if (rd_idx != wr_idx)
            begin
                flen = {16'd0, slot_length[rd_idx]};
                r.read_offset = slot_offset[rd_idx];
                r.read_length = (flen > {16'd0, req}) ? req : flen[15:0];
                nxt = ({28'd0, rd_idx} + 32'd1) % slots_eff();
                rd_idx = nxt[3:0];
                consumed += flen;
                frames++;
                r.frame_valid = 1'b1;
                r.frame_full_length = flen[15:0];
            end
        end
        else if (kind == KIND_REARM)
        begin
            written = '0;
            consumed = '0;
            frame_mark = '0;
            wr_idx = '0;
            rd_idx = '0;
            if (!dma_cfg)
                r.arm_length = len[15:0];
        end
        av = written - consumed;
        r.available = av[15:0];
        r.overrun_total = overruns;
        r.received_total = received;
        r.frames_total = frames;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t exp_r, act_r, new_r;
        if (!rst_n)
        begin
            ring_len_cfg <= RING_LEN_RESET;
            slots_cfg <= SLOTS_RESET;
            framing_cfg <= FRAMING_RESET;
            dma_cfg <= DMA_MODE_RESET;
            written = '0;
            consumed = '0;
            frame_mark = '0;
            wr_idx = '0;
            rd_idx = '0;
            overruns = '0;
            received = '0;
            frames = '0;
            for (int i = 0; i < 16; i++)
            begin
                slot_offset[i] = '0;
                slot_length[i] = '0;
            end
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            // retire the oldest expectation before adding a new one
            if (m_tvalid && m_tready)
            begin
                act_r = m_tdata;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat with no expectation, actual %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_beats.pop_front();
                    check_field("available", exp_r.available, act_r.available);
                    check_field("read_offset", exp_r.read_offset, act_r.read_offset);
                    check_field("read_length", exp_r.read_length, act_r.read_length);
                    check_field("frame_valid", exp_r.frame_valid, act_r.frame_valid);
                    check_field("frame_full_length", exp_r.frame_full_length,
                                act_r.frame_full_length);
                    check_field("ring_overrun", exp_r.ring_overrun, act_r.ring_overrun);
                    check_field("frame_dropped", exp_r.frame_dropped, act_r.frame_dropped);
                    check_field("arm_offset", exp_r.arm_offset, act_r.arm_offset);
                    check_field("arm_length", exp_r.arm_length, act_r.arm_length);
                    check_field("overrun_total", exp_r.overrun_total, act_r.overrun_total);
                    check_field("received_total", exp_r.received_total, act_r.received_total);
                    check_field("frames_total", exp_r.frames_total, act_r.frames_total);
                    check_field("zero fill", exp_r.fill, act_r.fill);
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_ring_accounting(s_tuser[2:0], s_tdata[15:0], s_tuser[3],
                                        s_tdata[31:16], new_r);
                expected_beats.push_back(new_r);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_RING_LENGTH:  ring_len_cfg <= pwdata[15:0];
                    REG_FRAME_SLOTS:  slots_cfg <= pwdata[4:0];
                    REG_IDLE_FRAMING: framing_cfg <= pwdata[0];
                    REG_DMA_MODE:     dma_cfg <= pwdata[0];
                    default: ;
                endcase
            end
            pending <= expected_beats.size();
        end
    end

    initial fail_count = 0;

endmodule

// File: tb/sv/tb.sv
module tb;
    import urrft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // position[15:0], request[31:16]
    logic [IN_USER_W-1:0]  s_tuser = '0;   // kind[2:0], idle_event[3]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // available up to frames_total, see checker
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;          // no stalls on either side in the closing phase
    int stall_left = 0;

    // ring length, slots, framing, mode for each phase; extremes first
    int phase_ring [NUM_PHASES] = '{64, 64, 1, 0, 65535, 65535, 300, 200, 17, 9, 1000, 48};
    int phase_slots[NUM_PHASES] = '{4, 4, 1, 0, 16, 31, 17, 2, 3, 5, 12, 8};
    int phase_frame[NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 0, 1};
    int phase_dma  [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0, 1};

    always #5 clk = ~clk;

    uart_rx_ring_frame_tracker DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ring_tracker_checker checker_inst
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: stalls at random, never in the quiet phase.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: count cycles where no beat and no register write moves.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold one beat until it is taken; optionally idle the sender first.
    task automatic send_event(input logic [2:0] kind, input logic [15:0] pos,
                              input logic idle, input logic [15:0] req);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {req, pos};
        s_tuser <= {idle, kind};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait for every result to come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || m_tvalid) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input int ring, input int slots, input int framing, input int dma);
        write_reg(REG_RING_LENGTH, ring);
        write_reg(REG_FRAME_SLOTS, slots);
        write_reg(REG_IDLE_FRAMING, framing);
        write_reg(REG_DMA_MODE, dma);
        // start from empty accounting so no descriptor slot is read before written
        send_event(KIND_REARM, 16'd0, 1'b0, 16'd0);
    endtask

    // Mostly well-formed traffic for the current mode, some noise.
    task automatic random_event(input int ring, input int dma, output bit counted);
        int pick, lim;
        logic [2:0] kind;
        logic [15:0] pos, req;
        logic idle;
        lim = (ring < 2) ? 2 : ((ring > 30000) ? 65535 : 2 * ring);
        pick = $urandom_range(0, 99);
        idle = 1'($urandom_range(0, 1));
        pos = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
        req = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
        if (!dma && $urandom_range(0, 3) != 0)
            pos = 16'($urandom_range(0, (ring < 8) ? 4 : ring / 3));
        if (pick < 42)
            kind = dma ? KIND_DMA_EVENT : KIND_SEG_END;
        else if (pick < 60)
            kind = KIND_STREAM_RD;
        else if (pick < 88)
            kind = KIND_FRAME_RD;
        else if (pick < 91)
            kind = KIND_REARM;
        else if (pick < 96)
            kind = dma ? KIND_SEG_END : KIND_DMA_EVENT;   // wrong mode, ignored
        else
            kind = 3'($urandom_range(5, 7));
        counted = (pick < 91);
        send_event(kind, pos, idle, req);
    endtask

    initial
    begin
        bit counted;
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, ignored kinds, wrap, empty frame ring.
        send_event(KIND_DMA_EVENT, 16'd0, 1'b0, 16'd0);
        send_event(KIND_DMA_EVENT, 16'd100, 1'b1, 16'd0);
        send_event(KIND_DMA_EVENT, 16'hFFFF, 1'b0, 16'hFFFF);
        send_event(KIND_STREAM_RD, 16'd0, 1'b0, 16'd0);
        send_event(KIND_STREAM_RD, 16'd0, 1'b0, 16'hFFFF);
        send_event(KIND_FRAME_RD, 16'd0, 1'b0, 16'hFFFF);
        send_event(KIND_SEG_END, 16'd40, 1'b0, 16'd0);
        send_event(3'd5, 16'hFFFF, 1'b1, 16'hFFFF);
        send_event(3'd6, 16'd1, 1'b0, 16'd1);
        send_event(3'd7, 16'd2, 1'b1, 16'd2);
        drain_results();

        // Directed: idle framing, capped frame read, overrun, single slot.
        set_config(256, 8, 1, 1);
        send_event(KIND_DMA_EVENT, 16'd10, 1'b1, 16'd0);
        send_event(KIND_DMA_EVENT, 16'd30, 1'b1, 16'd0);
        send_event(KIND_FRAME_RD, 16'd0, 1'b0, 16'd3);
        send_event(KIND_FRAME_RD, 16'd0, 1'b0, 16'hFFFF);
        send_event(KIND_DMA_EVENT, 16'd20, 1'b0, 16'd0);
        send_event(KIND_DMA_EVENT, 16'd19, 1'b0, 16'd0);
        drain_results();
        set_config(5, 1, 1, 1);
        send_event(KIND_DMA_EVENT, 16'd3, 1'b1, 16'd0);

        // Directed: interrupt path, long segment overrun, rearm.
        drain_results();
        set_config(256, 4, 1, 0);
        send_event(KIND_SEG_END, 16'd0, 1'b0, 16'd0);
        send_event(KIND_SEG_END, 16'd200, 1'b0, 16'd0);
        send_event(KIND_FRAME_RD, 16'd0, 1'b0, 16'd50);
        send_event(KIND_SEG_END, 16'd300, 1'b0, 16'd0);
        send_event(KIND_DMA_EVENT, 16'd9, 1'b1, 16'd0);
        send_event(KIND_REARM, 16'd0, 1'b0, 16'd0);
        drain_results();

        // Random phases; the last one runs without idling on either side.
        sent = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiet = (ph == NUM_PHASES - 1);
            set_config(phase_ring[ph], phase_slots[ph], phase_frame[ph], phase_dma[ph]);
            while (sent < (ph + 1) * 1350 / NUM_PHASES)
            begin
                random_event(phase_ring[ph], phase_dma[ph], counted);
                if (counted)
                    sent++;
            end
            drain_results();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
